@@ rtl/core/h2r_pkg.sv @@
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types, constants and helpers for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

    localparam int HUE_W  = 15;
    localparam int CH_W   = 8;
    localparam int SV_W   = 16;
    localparam int DIST_W = 12;
    localparam int PROD_W = SV_W + DIST_W;

    // One 60 degree sector in 1/64 degree units
    localparam logic [DIST_W-1:0] SECTOR_SPAN = 12'd3840;

    // floor(x/15) == (x*137) >> 11 for the 7-bit upper hue bits
    localparam logic [7:0] RECIP15_SMALL = 8'd137;
    localparam int         RECIP15_SMALL_SH = 11;

    // ceil(2^28/15); exact floor(y/15) for y < 2^20
    localparam logic [24:0] RECIP15_WIDE = 25'd17895698;
    localparam int          RECIP15_WIDE_SH = 28;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,   // red max, green rising
        SEC_YG = 3'd1,   // green max, red falling
        SEC_GC = 3'd2,   // green max, blue rising
        SEC_CB = 3'd3,   // blue max, green falling
        SEC_BM = 3'd4,   // blue max, red rising
        SEC_MR = 3'd5    // red max, blue falling (also out-of-range hue)
    } sector_t;

    typedef struct packed {
        logic [SV_W-1:0]   sv;
        logic [CH_W-1:0]   val;
        sector_t           sector;
        logic              odd;
        logic [DIST_W-1:0] rem;
    } s1_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [CH_W-1:0]   val;
        sector_t           sector;
        logic [CH_W-1:0]   zero_ch;
    } s2_t;

    typedef struct packed {
        logic [SV_W-1:0]   quot;
        logic [CH_W-1:0]   val;
        sector_t           sector;
        logic [CH_W-1:0]   zero_ch;
    } s3_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // ceil(x/255) for x <= 65025
    function automatic logic [CH_W-1:0] div255_ceil(input logic [SV_W-1:0] x);
        logic [SV_W:0] y;
        logic [SV_W:0] q;
        y = {1'b0, x} + 17'd254;
        q = (y + {8'd0, y[SV_W:8]} + 17'd1) >> 8;
        return q[CH_W-1:0];
    endfunction

endpackage

@@ rtl/core/h2r_prep.sv @@
// ----------------------------------------------------------------------------
// h2r_prep
// Stages 1 and 2: chroma product, sector split, distance product.
// ----------------------------------------------------------------------------
module h2r_prep (
    input  logic                    clk,
    input  logic                    en1,
    input  logic                    en2,
    input  logic [h2r_pkg::HUE_W-1:0] hue,
    input  logic [h2r_pkg::CH_W-1:0]  saturation,
    input  logic [h2r_pkg::CH_W-1:0]  brightness,
    output h2r_pkg::s2_t            s2
);
    import h2r_pkg::*;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;

    logic [14:0]       qprod;
    logic [3:0]        sec_raw;
    logic [7:0]        sec15;
    logic [HUE_W-1:0]  rem_full;
    logic [DIST_W-1:0] peak_dist;

    // Stage 1
    always_comb
    begin
        qprod    = {8'd0, hue[14:8]} * {7'd0, RECIP15_SMALL};
        sec_raw  = qprod[RECIP15_SMALL_SH +: 4];
        sec15    = {sec_raw, 4'd0} - {4'd0, sec_raw};
        rem_full = hue - {sec15[6:0], 8'd0};

        s1_next.sv     = {8'd0, saturation} * {8'd0, brightness};
        s1_next.val    = brightness;
        s1_next.odd    = sec_raw[0];
        s1_next.rem    = rem_full[DIST_W-1:0];
        s1_next.sector = (sec_raw >= 4'd5) ? SEC_MR : sector_t'(sec_raw[2:0]);
    end

    // Stage 2: distance from the sector peak, scaled by chroma
    always_comb
    begin
        peak_dist = s1_reg.odd ? s1_reg.rem : (SECTOR_SPAN - s1_reg.rem);

        s2_next.prod    = {{DIST_W{1'b0}}, s1_reg.sv} * {{SV_W{1'b0}}, peak_dist};
        s2_next.val     = s1_reg.val;
        s2_next.sector  = s1_reg.sector;
        s2_next.zero_ch = s1_reg.val - div255_ceil(s1_reg.sv);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

@@ rtl/core/h2r_scale.sv @@
// ----------------------------------------------------------------------------
// h2r_scale
// Stage 3: ceiling divide of the distance product by 256*15.
// ----------------------------------------------------------------------------
module h2r_scale (
    input  logic         clk,
    input  logic         en,
    input  h2r_pkg::s2_t s2,
    output h2r_pkg::s3_t s3
);
    import h2r_pkg::*;

    s3_t s3_reg, s3_next;

    logic [PROD_W:0] rounded;
    logic [19:0]     y;
    logic [44:0]     mprod;

    always_comb
    begin
        // ceil(/256) then ceil(/15) via reciprocal; prod + 255 stays below 2^28
        rounded = {1'b0, s2.prod} + 29'd255;
        y       = rounded[PROD_W-1:8] + 20'd14;
        mprod   = {25'd0, y} * {20'd0, RECIP15_WIDE};

        s3_next.quot    = mprod[RECIP15_WIDE_SH +: SV_W];
        s3_next.val     = s2.val;
        s3_next.sector  = s2.sector;
        s3_next.zero_ch = s2.zero_ch;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3 = s3_reg;

endmodule

@@ rtl/core/h2r_place.sv @@
// ----------------------------------------------------------------------------
// h2r_place
// Stage 4: final /255 ceiling, sector placement into R, G, B.
// ----------------------------------------------------------------------------
module h2r_place (
    input  logic          clk,
    input  logic          en,
    input  h2r_pkg::s3_t  s3,
    output h2r_pkg::rgb_t rgb
);
    import h2r_pkg::*;

    rgb_t rgb_reg, rgb_next;

    logic [CH_W-1:0] sec_ch;

    always_comb
    begin
        // max channel equals value; the others are at most value
        sec_ch = s3.val - div255_ceil(s3.quot);
        unique case (s3.sector)
            SEC_RY:  rgb_next = '{red: s3.val,     green: sec_ch,     blue: s3.zero_ch};
            SEC_YG:  rgb_next = '{red: sec_ch,     green: s3.val,     blue: s3.zero_ch};
            SEC_GC:  rgb_next = '{red: s3.zero_ch, green: s3.val,     blue: sec_ch};
            SEC_CB:  rgb_next = '{red: s3.zero_ch, green: sec_ch,     blue: s3.val};
            SEC_BM:  rgb_next = '{red: sec_ch,     green: s3.zero_ch, blue: s3.val};
            default: rgb_next = '{red: s3.val,     green: s3.zero_ch, blue: sec_ch};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule

@@ rtl/core/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Four-stage pipelined HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one HSV pixel per transfer: hue in 1/64 degree units
//   (0..23039), saturation and brightness as fractions of 255.
//   m_axis carries one RGB pixel per transfer, each channel rounded down.
//   Exactly one output transfer per input transfer, in order.
// Throughput: one pixel per clock unless m_axis stalls; the multiplier stages
//   (8x8 chroma, 16x12 distance product, 20x25 reciprocal divide) each sit in
//   their own register stage.
// Reset: rst_n clears all stage valid bits; the pipeline comes up empty and
//   ready.
// Stall: each stage holds while the next one is full and stalled; bubbles
//   are squeezed out, so s_axis_tready drops only once all four stages hold
//   pixels behind a stalled m_axis_tready. Nothing is lost or repeated.
// Hue of 23040 or more takes the red-max placement of the last sector (SEC_MR).
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [14:0] hue, [22:15] saturation,
                                        // [30:23] brightness, [31] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
    import h2r_pkg::*;

    logic [3:0] valid_reg, valid_next;
    logic [3:0] stage_en;

    s2_t  s2;
    s3_t  s3;
    rgb_t rgb;

    // Per-stage enable: a stage loads when it is empty or its successor moves
    always_comb
    begin
        stage_en[3] = !valid_reg[3] || m_axis_tready;
        stage_en[2] = !valid_reg[2] || stage_en[3];
        stage_en[1] = !valid_reg[1] || stage_en[2];
        stage_en[0] = !valid_reg[0] || stage_en[1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = s_axis_tvalid;
        end
        if (stage_en[1])
        begin
            valid_next[1] = valid_reg[0];
        end
        if (stage_en[2])
        begin
            valid_next[2] = valid_reg[1];
        end
        if (stage_en[3])
        begin
            valid_next[3] = valid_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stages 1-2: chroma, sector, distance product
    h2r_prep u_prep (
        .clk        (clk),
        .en1        (stage_en[0]),
        .en2        (stage_en[1]),
        .hue        (s_axis_tdata[14:0]),
        .saturation (s_axis_tdata[22:15]),
        .brightness (s_axis_tdata[30:23]),
        .s2         (s2)
    );

    // Stage 3: divide by 256*15
    h2r_scale u_scale (
        .clk (clk),
        .en  (stage_en[2]),
        .s2  (s2),
        .s3  (s3)
    );

    // Stage 4: divide by 255, place channels
    h2r_place u_place (
        .clk (clk),
        .en  (stage_en[3]),
        .s3  (s3),
        .rgb (rgb)
    );

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = valid_reg[3];
    assign m_axis_tdata  = {rgb.blue, rgb.green, rgb.red};

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hsv_to_rgb_converter: drives HSV pixels on s_axis,
// predicts each RGB pixel with exact integer math and checks m_axis in order.
// ----------------------------------------------------------------------------
module tb;
    import h2r_pkg::*;

    // Run-away guard, far above the slowest legal run (~1700 pixels with
    // heavy gaps and stalls plus one long output hold).
    localparam int CYCLE_LIMIT = 200000;
    // Pipeline is four stages deep; DRAIN_CYCLES is the extra drain at the end.
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS = 10;

    // Exact-rational scaling: everything is over 65025*3840.
    localparam int unsigned SPAN      = SECTOR_SPAN;
    localparam int unsigned SPAN2     = 2 * SPAN;
    localparam int unsigned CHAN_DIV  = 255 * SPAN;
    localparam int unsigned HUE_TOP   = 23039;
    localparam int unsigned HUE_MAX   = (1 << HUE_W) - 1;

    // One pending pixel: the input kept for the report, plus predicted RGB.
    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
        rgb_t             rgb;
    } pixel_check_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [14:0] hue, [22:15] saturation,
                                       // [30:23] brightness, [31] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] red, [15:8] green, [23:16] blue

    pixel_check_t pending_rgb[$];
    int           fail_count = 0;
    int           cycle_count = 0;

    // Idle knobs, percent of cycles, changed per test phase.
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    // Long output hold: the test bumps hold_requests, the ready process
    // notices the change and counts the hold down itself.
    int           hold_requests = 0;
    int           hold_seen = 0;
    int           hold_len = 0;
    int           hold_left = 0;

    hsv_to_rgb_converter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // (component + offset) / (255*3840), floored, saturated to a byte
    function automatic logic [CH_W-1:0] scale_channel(input int unsigned comp,
                                                      input int unsigned offs);
        int unsigned q;
        q = (comp + offs) / CHAN_DIV;
        return (q > 255) ? 8'd255 : q[CH_W-1:0];
    endfunction

    function automatic rgb_t predict_rgb(input logic [HUE_W-1:0] hue,
                                         input logic [CH_W-1:0]  sat,
                                         input logic [CH_W-1:0]  val);
        int unsigned sv;
        int unsigned chroma;
        int unsigned wrapped;
        int unsigned peak_dist;
        int unsigned second;
        int unsigned offs;
        int unsigned idx;
        int unsigned rc;
        int unsigned gc;
        int unsigned bc;
        sector_t     sec;
        rgb_t        px;
        sv      = int'(sat) * int'(val);
        chroma  = sv * SPAN;
        // triangle wave over two sectors: peaks at the sector edges
        wrapped   = int'(hue) % SPAN2;
        peak_dist = (wrapped >= SPAN) ? wrapped - SPAN : SPAN - wrapped;
        second    = sv * (SPAN - peak_dist);
        offs    = (255 * int'(val) - sv) * SPAN;
        // hue past 360 degrees takes the red-max placement of the last sector
        idx     = int'(hue) / SPAN;
        sec     = (idx >= 5) ? SEC_MR : sector_t'(idx[2:0]);
        case (sec)
            SEC_RY:  begin rc = chroma; gc = second; bc = 0;      end
            SEC_YG:  begin rc = second; gc = chroma; bc = 0;      end
            SEC_GC:  begin rc = 0;      gc = chroma; bc = second; end
            SEC_CB:  begin rc = 0;      gc = second; bc = chroma; end
            SEC_BM:  begin rc = second; gc = 0;      bc = chroma; end
            default: begin rc = chroma; gc = 0;      bc = second; end
        endcase
        px.red   = scale_channel(rc, offs);
        px.green = scale_channel(gc, offs);
        px.blue  = scale_channel(bc, offs);
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one pixel per call, random gaps ahead of it. tvalid is
    // left high after the transfer so back-to-back pixels need no re-raise.
    // ------------------------------------------------------------------------
    task automatic send_pixel(input logic [HUE_W-1:0] hue,
                              input logic [CH_W-1:0]  sat,
                              input logic [CH_W-1:0]  val);
        pixel_check_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val, sat, hue};
        do
            @(posedge clk);
        while (!s_axis_tready);
        // transfer happened at this edge
        want.hue = hue;
        want.sat = sat;
        want.val = val;
        want.rgb = predict_rgb(hue, sat, val);
        pending_rgb.push_back(want);
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready with random stalls, plus the long hold on request
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen     <= hold_requests;
            hold_left     <= hold_len;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every output transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_rgb
        pixel_check_t want;
        logic [CH_W-1:0] got_r;
        logic [CH_W-1:0] got_g;
        logic [CH_W-1:0] got_b;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_r = m_axis_tdata[7:0];
            got_g = m_axis_tdata[15:8];
            got_b = m_axis_tdata[23:16];
            if (pending_rgb.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected pixel rgb=%0d,%0d,%0d", got_r, got_g, got_b);
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (got_r !== want.rgb.red || got_g !== want.rgb.green ||
                    got_b !== want.rgb.blue)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("hsv=%0d,%0d,%0d expected rgb=%0d,%0d,%0d got %0d,%0d,%0d",
                                 want.hue, want.sat, want.val,
                                 want.rgb.red, want.rgb.green, want.rgb.blue,
                                 got_r, got_g, got_b);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // mostly uniform, now and then pinned to an end of the range
    function automatic logic [CH_W-1:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [HUE_W-1:0] pick_hue();
        case ($urandom_range(7))
            // any 15-bit code, including the out-of-range hues
            0:       return HUE_W'($urandom_range(HUE_MAX));
            // right around a sector edge
            1:       return HUE_W'($urandom_range(5) * SPAN + $urandom_range(2)
                                   - ($urandom_range(1) * 2));
            default: return HUE_W'($urandom_range(HUE_TOP));
        endcase
    endfunction

    // Sector edges, primaries, grays, black/white and out-of-range hue.
    task automatic test_corner_pixels();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pixel(15'd0,     8'd0,   8'd0);      // black
        send_pixel(15'd0,     8'd0,   8'd255);    // white
        send_pixel(15'd0,     8'd255, 8'd255);    // red
        send_pixel(15'd1920,  8'd255, 8'd255);    // mid-sector
        send_pixel(15'd3839,  8'd255, 8'd255);
        send_pixel(15'd3840,  8'd255, 8'd255);    // yellow
        send_pixel(15'd7679,  8'd128, 8'd255);
        send_pixel(15'd7680,  8'd255, 8'd255);    // green
        send_pixel(15'd11520, 8'd255, 8'd255);    // cyan
        send_pixel(15'd15360, 8'd255, 8'd255);    // blue
        send_pixel(15'd19200, 8'd255, 8'd255);    // magenta
        send_pixel(15'd23039, 8'd255, 8'd255);    // last legal hue
        send_pixel(15'd23040, 8'd255, 8'd255);    // first hue past 360
        send_pixel(15'd26880, 8'd200, 8'd100);
        send_pixel(15'd32767, 8'd255, 8'd255);    // all hue bits set
        send_pixel(15'd0,     8'd255, 8'd0);      // value zero
        send_pixel(15'd17000, 8'd0,   8'd200);    // gray
        send_pixel(15'd12345, 8'd1,   8'd1);
        send_pixel(15'd12345, 8'd255, 8'd128);
        send_pixel(15'd5000,  8'd255, 8'd1);
    endtask

    task automatic test_random_pixels(input int count, input int idle_pct,
                                      input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_pixel(pick_hue(), pick_byte(), pick_byte());
    endtask

    // Output held off long enough that all four stages fill and s_axis_tready
    // drops while pixels keep coming.
    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 200;
        hold_requests  = hold_requests + 1;
        repeat (40)
            send_pixel(pick_hue(), pick_byte(), pick_byte());
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_pixels();
        test_random_pixels(400, 0, 0);
        test_random_pixels(400, 64, 0);
        test_output_hold();
        test_random_pixels(400, 0, 64);
        test_random_pixels(400, 37, 37);

        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
        // catch any stray pixel trailing the last one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_rgb.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ hsv_to_rgb_converter.f @@
rtl/core/h2r_pkg.sv
rtl/core/h2r_prep.sv
rtl/core/h2r_scale.sv
rtl/core/h2r_place.sv
rtl/core/hsv_to_rgb_converter.sv
test/tb.sv
